### hw/rtl/gcs_pkg.sv
// shared types, constants and exp tables for the gaussian curve sampler
`default_nettype none
package gcs_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned NUM_W   = 7;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned PT_W    = 25;   // positions never wrap
   localparam int unsigned AD_W    = 25;
   localparam int unsigned SQ_W    = 2 * AD_W;
   localparam int unsigned REM_W   = 29;   // ad^2 below 4096*2*variance
   localparam int unsigned TV_W    = 17;
   localparam int unsigned E_W     = 12;
   localparam int unsigned DIV_STAGES = 4;
   localparam int unsigned BITS_PER_STAGE = 3;

   localparam logic [CSR_IDX_W-1:0] REG_VARIANCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_POINTS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PEAK_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
   } tag_type;

   // round(65536*exp(-k))
   function automatic logic [16:0] exp_int(input logic [3:0] k);
      logic [16:0] r;
      case (k)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd24109;
         4'd2:    r = 17'd8869;
         4'd3:    r = 17'd3263;
         4'd4:    r = 17'd1200;
         4'd5:    r = 17'd442;
         4'd6:    r = 17'd162;
         4'd7:    r = 17'd60;
         4'd8:    r = 17'd22;
         4'd9:    r = 17'd8;
         4'd10:   r = 17'd3;
         4'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // round(65536*exp(-h/16))
   function automatic logic [16:0] exp_hi(input logic [3:0] h);
      logic [16:0] r;
      case (h)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd61565;
         4'd2:    r = 17'd57835;
         4'd3:    r = 17'd54331;
         4'd4:    r = 17'd51039;
         4'd5:    r = 17'd47947;
         4'd6:    r = 17'd45042;
         4'd7:    r = 17'd42313;
         4'd8:    r = 17'd39750;
         4'd9:    r = 17'd37341;
         4'd10:   r = 17'd35079;
         4'd11:   r = 17'd32954;
         4'd12:   r = 17'd30957;
         4'd13:   r = 17'd29081;
         4'd14:   r = 17'd27319;
         default: r = 17'd25664;
      endcase
      return r;
   endfunction

   // round(65536*exp(-l/256))
   function automatic logic [16:0] exp_lo(input logic [3:0] l);
      logic [16:0] r;
      case (l)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd65280;
         4'd2:    r = 17'd65026;
         4'd3:    r = 17'd64772;
         4'd4:    r = 17'd64520;
         4'd5:    r = 17'd64268;
         4'd6:    r = 17'd64018;
         4'd7:    r = 17'd63768;
         4'd8:    r = 17'd63520;
         4'd9:    r = 17'd63272;
         4'd10:   r = 17'd63025;
         4'd11:   r = 17'd62780;
         4'd12:   r = 17'd62535;
         4'd13:   r = 17'd62291;
         4'd14:   r = 17'd62048;
         default: r = 17'd61806;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/gaussian_curve_sampler.sv
// gaussian curve sampler top level: step divider, point sequencer and value pipeline
`default_nettype none
// A beat on req_mean (start high while busy is low) produces num_points results, one per
// cycle, on rsp_value / rsp_point_index / rsp_last, strobed by rsp_valid; the receiver cannot
// stall. After the beat a one-bit-per-cycle divider works out the point step, then points
// enter the value pipeline every cycle, and busy stays high until the curve's last
// result has gone out. num_points of zero emits nothing; values above MAX_POINTS are
// clamped. Configuration registers may only be written while busy is low.
module gaussian_curve_sampler
   import gcs_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [15:0]   req_mean,
   output logic                      rsp_valid,
   output logic [15:0]               rsp_value,
   output logic [5:0]                rsp_point_index,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_POINTS);

   // configuration
   logic [15:0]        variance_ff, peak_height_ff;
   logic [NUM_W-1:0]   num_points_ff;
   logic signed [15:0] range_min_ff, range_max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         variance_ff    <= 16'd5120;
         num_points_ff  <= 7'd64;
         range_min_ff   <= 16'sd0;
         range_max_ff   <= 16'sd32512;
         peak_height_ff <= 16'd32512;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_VARIANCE:    variance_ff    <= csr_wdata;
            REG_NUM_POINTS:  num_points_ff  <= csr_wdata[NUM_W-1:0];
            REG_RANGE_MIN:   range_min_ff   <= csr_wdata;
            REG_RANGE_MAX:   range_max_ff   <= csr_wdata;
            REG_PEAK_HEIGHT: peak_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [TV_W-1:0] twovar;
   assign twovar = (variance_ff == 16'd0) ? TV_W'(2) : {variance_ff, 1'b0};

   // sequencer
   state_type state_ff, state_in;
   logic [NUM_W-1:0] n_eff;
   logic signed [16:0] diff;
   logic [15:0] mag;

   logic signed [15:0] mean_ff, mean_in;
   logic [NUM_W-1:0]   n_ff, n_in;
   logic [15:0]        dq_ff, dq_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic signed [16:0] step_ff, step_in;
   logic signed [PT_W-1:0] pt_ff, pt_in;
   logic [NUM_W-1:0]   idx_ff, idx_in;
   logic [NUM_W:0]     trial;
   logic               qbit;
   logic [15:0]        q_final;
   logic               s0_valid;
   logic               s0_last;
   logic               pipe_busy;

   assign n_eff = (num_points_ff > MAX_N) ? MAX_N : num_points_ff;
   assign diff  = 17'(range_max_ff) - 17'(range_min_ff);
   assign mag   = diff[16] ? 16'(-diff) : diff[15:0];
   assign trial = {rem_ff, dq_ff[15]};
   assign qbit  = (trial >= {1'b0, n_ff});
   assign q_final = {dq_ff[14:0], qbit};
   assign busy  = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mean_in  = mean_ff;
      n_in     = n_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      pt_in    = pt_ff;
      idx_in   = idx_ff;
      s0_valid = 1'b0;
      s0_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mean_in = req_mean;
               n_in    = n_eff;
               dq_in   = mag;
               rem_in  = '0;
               neg_in  = diff[16];
               cnt_in  = '0;
               if (n_eff != '0) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = qbit ? NUM_W'(trial - {1'b0, n_ff}) : trial[NUM_W-1:0];
            dq_in  = q_final;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               step_in  = neg_ff ? -$signed({1'b0, q_final}) : $signed({1'b0, q_final});
               pt_in    = PT_W'(range_min_ff);
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            s0_valid = 1'b1;
            s0_last  = (idx_ff == n_ff - 7'd1);
            pt_in    = pt_ff + PT_W'(step_ff);
            idx_in   = idx_ff + 7'd1;
            if (s0_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      n_ff    <= n_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      pt_ff   <= pt_in;
      idx_ff  <= idx_in;
   end

   // value pipeline
   logic                    v1_ff, v2_ff;
   tag_type                 t1_ff, t2_ff;
   logic [AD_W-1:0]         ad1_ff;
   logic [SQ_W-1:0]         sq2_ff;
   logic signed [PT_W:0]    d0;

   assign d0 = (PT_W+1)'(pt_ff) - (PT_W+1)'(mean_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= s0_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff  <= '{idx: idx_ff[IDX_W-1:0], last: s0_last};
      ad1_ff <= d0[PT_W] ? AD_W'(-d0) : AD_W'(d0);
      t2_ff  <= t1_ff;
      sq2_ff <= ad1_ff * ad1_ff;
   end

   // saturation check and the exponent divider stages; index 0 is the check stage
   logic               dv_ff  [0:DIV_STAGES];
   tag_type            dt_ff  [0:DIV_STAGES];
   logic               dsat_ff[0:DIV_STAGES];
   logic [REM_W-1:0]   drem_ff[0:DIV_STAGES];
   logic [E_W-1:0]     dq2_ff [0:DIV_STAGES];
   logic [REM_W-1:0]   lim;

   assign lim = {twovar, 12'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff[0]   <= t2_ff;
      dsat_ff[0] <= (sq2_ff[SQ_W-1:REM_W] != '0) || (sq2_ff[REM_W-1:0] >= lim);
      drem_ff[0] <= sq2_ff[REM_W-1:0];
      dq2_ff[0]  <= '0;
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [REM_W-1:0] r_in;
      logic [E_W-1:0]   q_in;

      always_comb begin
         logic [REM_W-1:0] cmp;
         r_in = drem_ff[g];
         q_in = dq2_ff[g];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            cmp = REM_W'(twovar) << (E_W - 1 - BITS_PER_STAGE * g - b);
            if (r_in >= cmp) begin
               r_in = r_in - cmp;
               q_in[E_W - 1 - BITS_PER_STAGE * g - b] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
         end else begin
            dv_ff[g+1] <= dv_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         dt_ff[g+1]   <= dt_ff[g];
         dsat_ff[g+1] <= dsat_ff[g];
         drem_ff[g+1] <= r_in;
         dq2_ff[g+1]  <= q_in;
      end
   end

   // exp from three tables and the height scaling
   logic             v8_ff, v9_ff;
   tag_type          t8_ff, t9_ff;
   logic             sat8_ff, sat9_ff;
   logic [3:0]       l8_ff;
   logic [16:0]      m8_ff, m9_ff;
   logic [E_W-1:0]   e7;
   logic [33:0]      p8, p9;
   logic [33:0]      p10;
   logic [17:0]      v10;

   assign e7  = dq2_ff[DIV_STAGES];
   assign p8  = exp_int(e7[11:8]) * exp_hi(e7[7:4]) + 34'd32768;
   assign p9  = m8_ff * exp_lo(l8_ff) + 34'd32768;
   assign p10 = 34'(peak_height_ff) * 34'(m9_ff) + 34'd32768;
   assign v10 = p10[33:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff     <= 1'b0;
         v9_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v8_ff     <= dv_ff[DIV_STAGES];
         v9_ff     <= v8_ff;
         rsp_valid <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      t8_ff   <= dt_ff[DIV_STAGES];
      sat8_ff <= dsat_ff[DIV_STAGES];
      l8_ff   <= e7[3:0];
      m8_ff   <= p8[32:16];
      t9_ff   <= t8_ff;
      sat9_ff <= sat8_ff;
      m9_ff   <= p9[32:16];
      rsp_point_index <= t9_ff.idx;
      rsp_last        <= t9_ff.last;
      if (sat9_ff) begin
         rsp_value <= 16'd0;
      end else if (v10[17:16] != 2'd0) begin
         rsp_value <= 16'hFFFF;
      end else begin
         rsp_value <= v10[15:0];
      end
   end

   always_comb begin
      pipe_busy = v1_ff | v2_ff | v8_ff | v9_ff | rsp_valid;
      for (int s = 0; s <= DIV_STAGES; s++) begin
         pipe_busy = pipe_busy | dv_ff[s];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/gcs_checker.sv
// port-level checks for the gaussian curve sampler, bound to the top level
`default_nettype none
module gcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [5:0]  rsp_point_index,
   input wire logic        rsp_last
);

   // results only come out while a curve is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while not busy");

   // a curve is emitted in back-to-back beats with rising indices
   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=>
         rsp_valid && (rsp_point_index == $past(rsp_point_index) + 6'd1))
      else $error("gap or index skip inside a curve");

   // each curve starts at point zero
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_point_index == 6'd0))
      else $error("curve does not start at point zero");

   // the last beat is followed by a gap
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("beat directly after last point");

   // nothing appears out of an idle block
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid)
      else $error("result beat without a trigger");

endmodule

bind gaussian_curve_sampler gcs_checker u_gcs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_point_index (rsp_point_index),
   .rsp_last        (rsp_last)
);
`default_nettype wire

### bench/gaussian_curve_sampler_checker.sv
// checker for the gaussian curve sampler: predicts every curve point and compares results
module gaussian_curve_sampler_checker
   import gcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic signed [15:0]   req_mean,
   input  logic                 rsp_valid,
   input  logic [15:0]          rsp_value,
   input  logic [5:0]           rsp_point_index,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   fail_count,
   output int                   points_pending,
   output int                   points_seen
);

   typedef struct {
      logic [15:0] value;
      logic [5:0]  point_index;
      logic        last;
   } curve_point_type;

   localparam int CURVE_MAX = 64;
   localparam longint unsigned EXP_CUTOFF = 4096;

   // own copies of the exp tables: whole powers, sixteenths, 1/256ths
   localparam longint unsigned WHOLE_TAB[16] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
      60, 22, 8, 3, 1, 0, 0, 0, 0};
   localparam longint unsigned SIXTEENTH_TAB[16] = '{65536, 61565, 57835, 54331, 51039,
      47947, 45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
   localparam longint unsigned FINE_TAB[16] = '{65536, 65280, 65026, 64772, 64520, 64268,
      64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

   logic [15:0]        cfg_variance;
   logic [6:0]         cfg_points;
   logic signed [15:0] cfg_min;
   logic signed [15:0] cfg_max;
   logic [15:0]        cfg_height;
   curve_point_type    points_due[$];
   int                 mismatches;

   function automatic logic [15:0] scaled_gauss(input longint unsigned e);
      longint unsigned m, v;
      if (e >= EXP_CUTOFF)
         return 16'd0;
      m = (WHOLE_TAB[(e >> 8) & 15] * SIXTEENTH_TAB[(e >> 4) & 15] + 32768) >> 16;
      m = (m * FINE_TAB[e & 15] + 32768) >> 16;
      v = (longint'(cfg_height) * m + 32768) >> 16;
      if (v > 65535)
         v = 65535;
      return v[15:0];
   endfunction

   task automatic queue_curve(input logic signed [15:0] mean);
      int n, step, lo, hi;
      longint pt, d;
      longint unsigned ad, twovar;
      curve_point_type p;
      n = int'(cfg_points);
      if (n > CURVE_MAX)
         n = CURVE_MAX;
      lo = int'(cfg_min);
      hi = int'(cfg_max);
      if (n == 0)
         return;
      step = (hi - lo) / n;
      twovar = 2 * ((cfg_variance == 0) ? 1 : longint'(cfg_variance));
      for (int i = 0; i < n; i++) begin
         pt = longint'(lo) + longint'(i) * step;
         d = pt - longint'(mean);
         ad = (d < 0) ? -d : d;
         p.value = scaled_gauss((ad * ad) / twovar);
         p.point_index = i[5:0];
         p.last = (i == n - 1);
         points_due.push_back(p);
      end
   endtask

   task automatic flag(input string what);
      fail_count++;
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      curve_point_type p;
      if (reset) begin
         cfg_variance <= 16'd5120;
         cfg_points   <= 7'd64;
         cfg_min      <= 16'sd0;
         cfg_max      <= 16'sd32512;
         cfg_height   <= 16'd32512;
         points_due.delete();
         fail_count = 0;
         mismatches = 0;
         points_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_VARIANCE:    cfg_variance <= csr_wdata;
               REG_NUM_POINTS:  cfg_points   <= csr_wdata[6:0];
               REG_RANGE_MIN:   cfg_min      <= csr_wdata;
               REG_RANGE_MAX:   cfg_max      <= csr_wdata;
               REG_PEAK_HEIGHT: cfg_height   <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            points_seen++;
            if (points_due.size() == 0) begin
               flag($sformatf("unexpected point value=%h idx=%0d last=%0d",
                  rsp_value, rsp_point_index, rsp_last));
            end else begin
               p = points_due.pop_front();
               if (p.value !== rsp_value || p.point_index !== rsp_point_index ||
                   p.last !== rsp_last)
                  flag($sformatf("exp value=%h idx=%0d last=%0d, got value=%h idx=%0d last=%0d",
                     p.value, p.point_index, p.last, rsp_value, rsp_point_index, rsp_last));
            end
         end
         if (start && !busy)
            queue_curve(req_mean);
      end
      points_pending = points_due.size();
   end

endmodule

### bench/gaussian_curve_sampler_test.sv
// testbench top for the gaussian curve sampler: stimulus, idling phases and verdict
module gaussian_curve_sampler_test
   import gcs_pkg::*;
();

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [15:0]   req_mean;
   logic                 rsp_valid;
   logic [15:0]          rsp_value;
   logic [5:0]           rsp_point_index;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;
   int                   fail_count;
   int                   points_pending;
   int                   points_seen;
   int                   curves_sent;
   int                   quiet_cycles;
   int                   sender_idle;
   logic signed [15:0]   span_lo;
   logic signed [15:0]   span_hi;

   gaussian_curve_sampler u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_mean(req_mean),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_point_index(rsp_point_index),
      .rsp_last(rsp_last), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   gaussian_curve_sampler_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_mean(req_mean),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_point_index(rsp_point_index),
      .rsp_last(rsp_last), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .points_pending(points_pending), .points_seen(points_seen)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog expired with %0d points outstanding", points_pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_RANGE_MIN)
         span_lo = data;
      if (idx == REG_RANGE_MAX)
         span_hi = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_mean(input logic signed [15:0] mean);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_mean <= mean;
      do @(posedge clock); while (busy);
      curves_sent++;
   endtask

   // stop sending and let every expected point come out before touching registers
   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (points_pending != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_curve(input logic [15:0] var_q, input logic [6:0] n,
                            input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] height);
      drain();
      write_reg(REG_VARIANCE, var_q);
      write_reg(REG_NUM_POINTS, {9'd0, n});
      write_reg(REG_RANGE_MIN, lo);
      write_reg(REG_RANGE_MAX, hi);
      write_reg(REG_PEAK_HEIGHT, height);
   endtask

   task automatic random_curve;
      logic [15:0] v;
      logic [6:0]  n;
      case ($urandom_range(0, 3))
         0:       v = 16'($urandom_range(0, 255));
         1:       v = 16'hFFFF;
         default: v = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       n = 7'd0;
         1:       n = 7'($urandom_range(65, 127));
         2:       n = 7'd64;
         default: n = 7'($urandom_range(1, 16));
      endcase
      set_curve(v, n, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic logic signed [15:0] pick_mean;
      int lo, hi;
      lo = int'(span_lo);
      hi = int'(span_hi);
      // mostly inside the sampled span so values are not all zero
      if ($urandom_range(0, 3) == 0)
         return 16'($urandom);
      return 16'(lo + ((hi - lo) * int'($urandom_range(0, 100))) / 100);
   endfunction

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mean = '0;
      csr_valid = 1'b0;
      csr_index = REG_VARIANCE;
      csr_wdata = '0;
      curves_sent = 0;
      sender_idle = 0;
      span_lo = 16'sd0;
      span_hi = 16'sd32512;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, extremes of the mean
      send_mean(16'sd0);
      send_mean(-16'sd32768);
      send_mean(16'sd32767);
      send_mean(16'sh4000);
      // zero variance, single point, full height
      set_curve(16'd0, 7'd1, 16'h0100, 16'h0200, 16'hFFFF);
      send_mean(16'sh0100);
      send_mean(16'sh0180);
      // widest span, largest variance, zero height then a wide curve
      set_curve(16'hFFFF, 7'd64, 16'h8000, 16'h7FFF, 16'd0);
      send_mean(16'sd0);
      set_curve(16'hFFFF, 7'd64, 16'h8000, 16'h7FFF, 16'hFFFF);
      send_mean(-16'sd32768);
      send_mean(16'sd32767);
      // reversed range runs downward; equal ends stay put
      set_curve(16'h0400, 7'd10, 16'h7FFF, 16'h8000, 16'h8000);
      send_mean(16'sd0);
      set_curve(16'h0400, 7'd5, 16'h1000, 16'h1000, 16'h4000);
      send_mean(16'sh1000);
      // more points than the block holds, then none at all
      set_curve(16'h1400, 7'd127, 16'h0000, 16'h4000, 16'h7F00);
      send_mean(16'sh2000);
      set_curve(16'h1400, 7'd0, 16'h0000, 16'h4000, 16'h7F00);
      send_mean(16'sh2000);
      send_mean(16'sh1000);
      // writes to unused indexes must leave the curve alone
      drain();
      write_reg(REG_SPARE_LO, 16'hFFFF);
      write_reg(REG_SPARE_HI, 16'h0000);
      write_reg(REG_NUM_POINTS, 16'd3);
      send_mean(16'sh2000);
      send_mean(16'sh3FFF);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       sender_idle = 0;
            1:       sender_idle = 70;
            2:       sender_idle = 10;
            default: sender_idle = 0;
         endcase
         for (int k = 0; k < 63; k++) begin
            if (k % 9 == 0)
               random_curve();
            if (phase == 3)
               sender_idle = (k % 20 < 10) ? 70 : 0;
            send_mean(pick_mean());
         end
      end

      drain();
      $display("%0d curves sent, %0d points checked over directed and random configurations",
         curves_sent, points_seen);
      $display("idling phases: none, sender 70%%, sender 10%%, alternating stretches");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
